// ===== design/bsg_pkg.sv =====
// bsg_pkg: shared types and constants for the bmp stream to grayscale unit
// result record, push bundle, header field offsets and gray weights
// no dependencies
`default_nettype none

package bsg_pkg;

    // result kinds
    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    // error codes
    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_PREMATURE = 3'd1,
        ERR_SIGNATURE = 3'd2,
        ERR_FORMAT    = 3'd3,
        ERR_SIZE      = 3'd4
    } t_err;

    localparam int COORD_W = 12;

    typedef struct packed {
        t_kind                kind;
        logic [7:0]           gray;
        logic [COORD_W-1:0]   column;
        logic [COORD_W-1:0]   row;
        t_err                 error_code;
        logic                 last;
    } t_result;

    // up to two results per input beat, slot 0 first
    typedef struct packed {
        logic [1:0]           count;
        t_result [1:0]        item;
    } t_push;

    // header layout, byte positions within the 54-byte header
    localparam logic [31:0] HDR_LEN        = 32'd54;
    localparam logic [5:0]  HDR_SIG_POS    = 6'd0;
    localparam logic [5:0]  HDR_OFFSET_POS = 6'd10;
    localparam logic [5:0]  HDR_WIDTH_POS  = 6'd18;
    localparam logic [5:0]  HDR_HEIGHT_POS = 6'd22;
    localparam logic [5:0]  HDR_BPP_POS    = 6'd28;
    localparam logic [5:0]  HDR_COMPR_POS  = 6'd30;

    localparam logic [15:0] BM_SIGNATURE   = 16'h4D42;
    localparam logic [15:0] BPP_24         = 16'd24;
    localparam logic [15:0] BPP_32         = 16'd32;

    // gray = floor((11 b + 59 g + 30 r) / 100), divide by reciprocal
    localparam int          GRAY_SUM_W     = 15;
    localparam logic [3:0]  W_BLUE         = 4'd11;
    localparam logic [5:0]  W_GREEN        = 6'd59;
    localparam logic [4:0]  W_RED          = 5'd30;
    localparam logic [12:0] GRAY_RECIP     = 13'd5243;
    localparam int          GRAY_SHIFT     = 19;

    localparam int          FIFO_DEPTH     = 4;

endpackage

`default_nettype wire

// ===== design/bmp_stream_to_grayscale_unit.sv =====
// channel   direction  handshake                     payload
// input     in         i_in_valid / o_in_stall       i_data_byte, i_end_of_file
// result    out        o_out_valid / i_out_stall     o_kind, o_gray, o_column,
//                                                    o_row, o_error_code, o_last
//
// one input beat per cycle when results are taken as fast as they come
// a beat is registered, parsed combinationally, its results land in a 4-deep queue
// results are valid once their registered beat is parsed and written to the queue
// a beat that makes two results needs an extra output beat; the queue absorbs it
// input stalls only while the result queue lacks room for two results
// synchronous active-low reset returns the parser to the start of a file header
//
// top level of the bmp stream to grayscale unit
// depends on bsg_pkg, bsg_parser, bsg_result_fifo
`default_nettype none

module bmp_stream_to_grayscale_unit #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input beats: one file byte each
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_file,
    // result beats
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_gray,
    output logic [11:0]      o_column,
    output logic [11:0]      o_row,
    output logic [2:0]       o_error_code,
    output logic             o_last
);
    import bsg_pkg::*;

    t_push      w_push;
    t_result    w_head;
    logic       w_room;
    logic [2:0] w_fifo_level;

    // header capture, skip, pixel grouping and gray computation
    bsg_parser #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .i_end_of_file (i_end_of_file),
        .i_room        (w_room),
        .o_push        (w_push)
    );

    // result queue decouples the two channels
    bsg_result_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .o_room      (w_room),
        .o_level     (w_fifo_level),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_head      (w_head)
    );

    // unpack the head result onto the ports
    assign o_kind       = w_head.kind;
    assign o_gray       = w_head.gray;
    assign o_column     = w_head.column;
    assign o_row        = w_head.row;
    assign o_error_code = w_head.error_code;
    assign o_last       = w_head.last;

`ifndef SYNTH
    // queue never overfills from a two-result beat
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fifo_level + {1'b0, w_push.count}) <= 3'(FIFO_DEPTH))
        else $error("result queue overflow");

    // input stalls only when the queue is nearly full
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (w_fifo_level > 3'(FIFO_DEPTH - 2)))
        else $error("input stalled with room in queue");

    // nothing to deliver right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // pixels never carry an error code
    a_pixel_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_PIXEL) |-> (o_error_code == ERR_NONE))
        else $error("pixel result with error code");
`endif

endmodule

`default_nettype wire

// ===== design/bsg_gray.sv =====
// bsg_gray: weighted sum of b, g, r and divide by 100 via reciprocal multiply
// uses bsg_pkg for weights and the reciprocal constant
// exact for every sum up to 25500
`default_nettype none

module bsg_gray (
    input  wire logic [bsg_pkg::GRAY_SUM_W-1:0] i_bg_sum,
    input  wire logic [7:0]                     i_red,
    output logic [7:0]                          o_gray
);
    import bsg_pkg::*;

    logic [GRAY_SUM_W-1:0]    w_sum;
    logic [GRAY_SUM_W+12:0]   w_prod;

    assign w_sum  = i_bg_sum + GRAY_SUM_W'(W_RED) * GRAY_SUM_W'(i_red);
    assign w_prod = (GRAY_SUM_W+13)'(w_sum) * (GRAY_SUM_W+13)'(GRAY_RECIP);
    assign o_gray = w_prod[GRAY_SHIFT +: 8];

endmodule

`default_nettype wire

// ===== design/bsg_result_fifo.sv =====
// bsg_result_fifo: small result queue, up to two writes and one read a cycle
// uses bsg_pkg result and push types
`default_nettype none

module bsg_result_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire bsg_pkg::t_push  i_push,
    output logic                 o_room,
    output logic [2:0]           o_level,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output bsg_pkg::t_result     o_head
);
    import bsg_pkg::*;

    t_result    r_mem [FIFO_DEPTH];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_level;
    logic [1:0] n_wr_ptr;
    logic [1:0] n_rd_ptr;
    logic [2:0] n_level;
    logic       w_pop;

    assign w_pop       = (r_level != 3'd0) && !i_out_stall;
    assign o_out_valid = (r_level != 3'd0);
    assign o_head      = r_mem[r_rd_ptr];
    // room for a full pair of results
    assign o_room      = (r_level <= 3'(FIFO_DEPTH - 2));
    assign o_level     = r_level;

    always_comb begin
        n_wr_ptr = r_wr_ptr + i_push.count;
        n_rd_ptr = r_rd_ptr + {1'b0, w_pop};
        n_level  = r_level + {1'b0, i_push.count} - {2'b00, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.item[0];
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr_ptr + 2'd1] <= i_push.item[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

endmodule

`default_nettype wire

// ===== design/bsg_parser.sv =====
// bsg_parser: input register, header capture and check, pixel grouping
// drives up to two results per beat into the result queue
// uses bsg_pkg and bsg_gray
`default_nettype none

module bsg_parser #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic           i_end_of_file,
    input  wire logic           i_room,
    output bsg_pkg::t_push      o_push
);
    import bsg_pkg::*;

    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int HB = $clog2(MAX_HEIGHT + 1);
    localparam int RB = WB + 3;

    typedef enum logic [1:0] {
        PH_HDR,
        PH_SKIP,
        PH_PIX,
        PH_DRAIN
    } t_phase;

    // input stage
    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_eof;
    logic                  w_proc;

    // parse state
    t_phase                r_phase,        n_phase;
    logic [31:0]           r_byte_pos,     n_byte_pos;
    logic [15:0]           r_signature,    n_signature;
    logic [31:0]           r_pixel_offset, n_pixel_offset;
    logic [31:0]           r_image_width,  n_image_width;
    logic [31:0]           r_image_height, n_image_height;
    logic [15:0]           r_bpp,          n_bpp;
    logic [31:0]           r_compression,  n_compression;
    logic [1:0]            r_byte_in_pix,  n_byte_in_pix;
    logic [7:0]            r_blue_held,    n_blue_held;
    logic [GRAY_SUM_W-1:0] r_bg_sum,       n_bg_sum;
    logic [RB-1:0]         r_row_bytes,    n_row_bytes;
    logic [HB-1:0]         r_row_count,    n_row_count;
    logic [WB-1:0]         r_col,          n_col;
    logic [RB-1:0]         r_rowdata,      n_rowdata;
    logic [RB-1:0]         r_padded,       n_padded;
    logic [HB-1:0]         r_hm,           n_hm;
    logic                  r_topdown,      n_topdown;
    logic                  r_four,         n_four;

    logic [7:0]            w_gray;
    logic [5:0]            w_p6;
    logic [5:0]            w_rel_sig;
    logic [5:0]            w_rel_off;
    logic [5:0]            w_rel_wid;
    logic [5:0]            w_rel_hgt;
    logic [5:0]            w_rel_bpp;
    logic [5:0]            w_rel_cmp;
    logic [31:0]           w_hm32;
    t_err                  w_hdr_err;
    logic [RB-1:0]         w_width_r;
    logic [RB-1:0]         w_rowdata;
    logic [RB-1:0]         w_row_bytes_inc;
    logic [2:0]            w_bip_inc;
    logic [2:0]            w_pix_bytes;
    logic [31:0]           w_row_out;
    logic [31:0]           w_col_out;
    logic [1:0]            w_cnt;
    t_push                 n_push;

    assign w_proc     = r_in_valid && i_room;
    assign o_in_stall = r_in_valid && !i_room;

    bsg_gray u_gray (
        .i_bg_sum (r_bg_sum),
        .i_red    (r_in_byte),
        .o_gray   (w_gray)
    );

    // header field lanes
    assign w_p6      = r_byte_pos[5:0];
    assign w_rel_sig = w_p6 - HDR_SIG_POS;
    assign w_rel_off = w_p6 - HDR_OFFSET_POS;
    assign w_rel_wid = w_p6 - HDR_WIDTH_POS;
    assign w_rel_hgt = w_p6 - HDR_HEIGHT_POS;
    assign w_rel_bpp = w_p6 - HDR_BPP_POS;
    assign w_rel_cmp = w_p6 - HDR_COMPR_POS;

    // header check, all fields are complete before the last header byte
    assign w_hm32 = r_image_height[31] ? (~r_image_height + 32'd1) : r_image_height;

    always_comb begin
        if (r_signature != BM_SIGNATURE) begin
            w_hdr_err = ERR_SIGNATURE;
        end else if ((r_bpp != BPP_24 && r_bpp != BPP_32) || r_compression != 32'd0) begin
            w_hdr_err = ERR_FORMAT;
        end else if (r_pixel_offset < HDR_LEN || r_image_width[31] ||
                     r_image_width == 32'd0 || r_image_width > 32'(MAX_WIDTH) ||
                     w_hm32 == 32'd0 || w_hm32 > 32'(MAX_HEIGHT)) begin
            w_hdr_err = ERR_SIZE;
        end else begin
            w_hdr_err = ERR_NONE;
        end
    end

    // row bytes for 3 or 4 byte pixels, valid once the width passed its check
    assign w_width_r = RB'(r_image_width[WB-1:0]);
    assign w_rowdata = (r_bpp == BPP_32) ? (w_width_r << 2)
                                         : ((w_width_r << 1) + w_width_r);

    assign w_row_bytes_inc = r_row_bytes + RB'(1);
    assign w_bip_inc       = {1'b0, r_byte_in_pix} + 3'd1;
    assign w_pix_bytes     = r_four ? 3'd4 : 3'd3;
    assign w_row_out       = r_topdown ? 32'(r_row_count)
                                       : (32'(r_hm) - 32'd1 - 32'(r_row_count));
    assign w_col_out       = 32'(r_col);

    always_comb begin
        n_phase        = r_phase;
        n_byte_pos     = r_byte_pos;
        n_signature    = r_signature;
        n_pixel_offset = r_pixel_offset;
        n_image_width  = r_image_width;
        n_image_height = r_image_height;
        n_bpp          = r_bpp;
        n_compression  = r_compression;
        n_byte_in_pix  = r_byte_in_pix;
        n_blue_held    = r_blue_held;
        n_bg_sum       = r_bg_sum;
        n_row_bytes    = r_row_bytes;
        n_row_count    = r_row_count;
        n_col          = r_col;
        n_rowdata      = r_rowdata;
        n_padded       = r_padded;
        n_hm           = r_hm;
        n_topdown      = r_topdown;
        n_four         = r_four;
        n_push         = '0;
        w_cnt          = 2'd0;

        unique case (r_phase)
            PH_HDR: begin
                n_byte_pos = r_byte_pos + 32'd1;
                if (w_rel_sig < 6'd2) begin
                    n_signature[{w_rel_sig[0], 3'b000} +: 8] = r_in_byte;
                end
                if (w_rel_off < 6'd4) begin
                    n_pixel_offset[{w_rel_off[1:0], 3'b000} +: 8] = r_in_byte;
                end
                if (w_rel_wid < 6'd4) begin
                    n_image_width[{w_rel_wid[1:0], 3'b000} +: 8] = r_in_byte;
                end
                if (w_rel_hgt < 6'd4) begin
                    n_image_height[{w_rel_hgt[1:0], 3'b000} +: 8] = r_in_byte;
                end
                if (w_rel_bpp < 6'd2) begin
                    n_bpp[{w_rel_bpp[0], 3'b000} +: 8] = r_in_byte;
                end
                if (w_rel_cmp < 6'd4) begin
                    n_compression[{w_rel_cmp[1:0], 3'b000} +: 8] = r_in_byte;
                end
                if (r_byte_pos == HDR_LEN - 32'd1) begin
                    if (w_hdr_err != ERR_NONE) begin
                        n_push.item[w_cnt[0]].kind       = KIND_ERROR;
                        n_push.item[w_cnt[0]].error_code = w_hdr_err;
                        w_cnt   = w_cnt + 2'd1;
                        n_phase = PH_DRAIN;
                    end else begin
                        n_phase   = (r_pixel_offset == HDR_LEN) ? PH_PIX : PH_SKIP;
                        n_rowdata = w_rowdata;
                        n_padded  = (w_rowdata + RB'(3)) & ~RB'(3);
                        n_hm      = w_hm32[HB-1:0];
                        n_topdown = r_image_height[31];
                        n_four    = (r_bpp == BPP_32);
                    end
                end
            end
            PH_SKIP: begin
                n_byte_pos = r_byte_pos + 32'd1;
                if (n_byte_pos == r_pixel_offset) begin
                    n_phase = PH_PIX;
                end
            end
            PH_PIX: begin
                n_byte_pos = r_byte_pos + 32'd1;
                if (r_row_bytes < r_rowdata) begin
                    case (r_byte_in_pix)
                        2'd0: n_blue_held = r_in_byte;
                        2'd1: n_bg_sum = GRAY_SUM_W'(W_BLUE) * GRAY_SUM_W'(r_blue_held)
                                       + GRAY_SUM_W'(W_GREEN) * GRAY_SUM_W'(r_in_byte);
                        2'd2: begin
                            n_push.item[w_cnt[0]].kind   = KIND_PIXEL;
                            n_push.item[w_cnt[0]].gray   = w_gray;
                            n_push.item[w_cnt[0]].column = w_col_out[COORD_W-1:0];
                            n_push.item[w_cnt[0]].row    = w_row_out[COORD_W-1:0];
                            w_cnt = w_cnt + 2'd1;
                            n_col = r_col + WB'(1);
                        end
                        default: ;
                    endcase
                    n_byte_in_pix = (w_bip_inc >= w_pix_bytes) ? 2'd0 : w_bip_inc[1:0];
                end
                n_row_bytes = w_row_bytes_inc;
                if (w_row_bytes_inc == r_padded) begin
                    n_row_bytes   = '0;
                    n_byte_in_pix = 2'd0;
                    n_col         = '0;
                    n_row_count   = r_row_count + HB'(1);
                    if (r_row_count + HB'(1) == r_hm) begin
                        n_push.item[w_cnt[0]].kind = KIND_DONE;
                        w_cnt   = w_cnt + 2'd1;
                        n_phase = PH_DRAIN;
                    end
                end
            end
            PH_DRAIN: begin
                n_phase = PH_DRAIN;
            end
            default: ;
        endcase

        if (r_in_eof) begin
            if (n_phase != PH_DRAIN) begin
                n_push.item[w_cnt[0]].kind       = KIND_ERROR;
                n_push.item[w_cnt[0]].error_code = ERR_PREMATURE;
                w_cnt = w_cnt + 2'd1;
            end
            // next byte starts a new file
            n_phase        = PH_HDR;
            n_byte_pos     = '0;
            n_signature    = '0;
            n_pixel_offset = '0;
            n_image_width  = '0;
            n_image_height = '0;
            n_bpp          = '0;
            n_compression  = '0;
            n_byte_in_pix  = '0;
            n_blue_held    = '0;
            n_bg_sum       = '0;
            n_row_bytes    = '0;
            n_row_count    = '0;
            n_col          = '0;
            n_rowdata      = '0;
            n_padded       = '0;
            n_hm           = '0;
            n_topdown      = 1'b0;
            n_four         = 1'b0;
        end

        if (w_cnt != 2'd0) begin
            n_push.item[w_cnt[0] ^ 1'b1].last = 1'b1;
        end
        n_push.count = w_proc ? w_cnt : 2'd0;
    end

    assign o_push = n_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_in_byte      <= '0;
            r_in_eof       <= 1'b0;
            r_phase        <= PH_HDR;
            r_byte_pos     <= '0;
            r_signature    <= '0;
            r_pixel_offset <= '0;
            r_image_width  <= '0;
            r_image_height <= '0;
            r_bpp          <= '0;
            r_compression  <= '0;
            r_byte_in_pix  <= '0;
            r_blue_held    <= '0;
            r_bg_sum       <= '0;
            r_row_bytes    <= '0;
            r_row_count    <= '0;
            r_col          <= '0;
            r_rowdata      <= '0;
            r_padded       <= '0;
            r_hm           <= '0;
            r_topdown      <= 1'b0;
            r_four         <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
                r_in_byte  <= i_data_byte;
                r_in_eof   <= i_end_of_file;
            end
            if (w_proc) begin
                r_phase        <= n_phase;
                r_byte_pos     <= n_byte_pos;
                r_signature    <= n_signature;
                r_pixel_offset <= n_pixel_offset;
                r_image_width  <= n_image_width;
                r_image_height <= n_image_height;
                r_bpp          <= n_bpp;
                r_compression  <= n_compression;
                r_byte_in_pix  <= n_byte_in_pix;
                r_blue_held    <= n_blue_held;
                r_bg_sum       <= n_bg_sum;
                r_row_bytes    <= n_row_bytes;
                r_row_count    <= n_row_count;
                r_col          <= n_col;
                r_rowdata      <= n_rowdata;
                r_padded       <= n_padded;
                r_hm           <= n_hm;
                r_topdown      <= n_topdown;
                r_four         <= n_four;
            end
        end
    end

endmodule

`default_nettype wire
